@@ hdl/bcd_amd_pkg.sv @@
// ----------------------------------------------------------------------------
// bcd_amd_pkg
// Shared constants and types for the BCD add/multiply/divide core.
// ----------------------------------------------------------------------------
package bcd_amd_pkg;

  localparam int unsigned Digits = 16;
  localparam int unsigned DataW  = 64;
  localparam int unsigned IdxW   = (Digits > 1) ? $clog2(Digits) : 1;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_MUL = 2'd1,
    OP_DIV = 2'd2,
    OP_RSV = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_DIVZERO  = 2'd2,
    ST_INVALID  = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [DataW-1:0] operand_a;
    logic [DataW-1:0] operand_b;
  } req_t;

  typedef struct packed {
    logic [DataW-1:0] result_value;
    logic [1:0]       status;
  } rsp_t;

endpackage

@@ hdl/bcd_amd_if.sv @@
// ----------------------------------------------------------------------------
// bcd_amd_req_if / bcd_amd_rsp_if
// Valid/ready channels carrying requests and results.
// ----------------------------------------------------------------------------
interface bcd_amd_req_if;
  logic                  valid;
  logic                  ready;
  bcd_amd_pkg::req_t     payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface bcd_amd_rsp_if;
  logic                  valid;
  logic                  ready;
  bcd_amd_pkg::rsp_t     payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ hdl/bcd_add_multiply_divide_core.sv @@
// ----------------------------------------------------------------------------
// bcd_add_multiply_divide_core
// Iterative BCD unit: one shared digit adder/subtractor under a sequencer.
// Sequencing: add makes one 32-digit add pass; multiply makes one 32-digit add
//   pass per unit of each multiplier digit; divide makes up to ten 32-digit
//   trial subtractions per quotient digit; reserved opcode, invalid digit and
//   zero divisor are answered straight from idle.
// Throughput: one transaction at a time; ready only in idle with no result pending.
// Reset: asynchronous, active low; returns to idle with no result pending.
// ----------------------------------------------------------------------------
module bcd_add_multiply_divide_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  bcd_amd_req_if.sink       req_i,
  bcd_amd_rsp_if.source     rsp_o
);
  import bcd_amd_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ADD  = 3'd1; // acc = acc + x (digit serial), x = b or shifted a
  localparam logic [2:0] S_MULN = 3'd2; // set up next multiplier digit
  localparam logic [2:0] S_SUB  = 3'd3; // trial subtract rem - shifted b
  localparam logic [2:0] S_DIVN = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  localparam int unsigned AccD = 2 * Digits;

  logic [2:0]         state_q, state_d;
  logic [1:0]         op_q, op_d;
  logic [4*AccD-1:0]  acc_q, acc_d;   // sum / product / remainder
  logic [4*AccD-1:0]  x_q, x_d;       // addend or shifted divisor
  logic [4*AccD-1:0]  t_q, t_d;       // trial difference
  logic [4*Digits-1:0] q_q, q_d;      // multiplier digits / quotient
  logic [3:0]         cnt_q, cnt_d;   // repeat count for digit
  logic [IdxW:0]      di_q, di_d;     // outer digit index
  logic [$clog2(AccD+1)-1:0] k_q, k_d; // digit position of serial unit
  logic               cy_q, cy_d;
  logic               busy_q, busy_d;
  logic               vld_q, vld_d;
  rsp_t               rsp_q, rsp_d;

  // shared digit add/sub unit
  logic [3:0] ua, ub, ur;
  logic       ucy;
  logic       usub;
  logic [4:0] usum;
  logic [$clog2(AccD)-1:0] kx;
  assign kx   = k_q[$clog2(AccD)-1:0];
  assign ua   = acc_q[4*kx +: 4];
  assign ub   = x_q[4*kx +: 4];
  always_comb begin
    if (usub) begin
      usum = {1'b0, ua} - {1'b0, ub} - {4'd0, cy_q};
      if (usum[4]) begin
        ur  = 4'(usum[3:0] + 4'd10);
        ucy = 1'b1;
      end else begin
        ur  = usum[3:0];
        ucy = 1'b0;
      end
    end else begin
      usum = {1'b0, ua} + {1'b0, ub} + {4'd0, cy_q};
      if (usum > 5'd9) begin
        ur  = 4'(usum - 5'd10);
        ucy = 1'b1;
      end else begin
        ur  = usum[3:0];
        ucy = 1'b0;
      end
    end
  end

  function automatic logic bad_digits(input logic [4*Digits-1:0] v);
    logic bad;
    bad = 1'b0;
    for (int i = 0; i < Digits; i++) bad |= (v[4*i +: 4] > 4'd9);
    return bad;
  endfunction

  logic [4*Digits-1:0] ain, bin;
  logic [3:0] mdig;
  logic [IdxW-1:0] qdx;               // quotient digit being built
  assign ain = req_i.payload.operand_a[4*Digits-1:0];
  assign bin = req_i.payload.operand_b[4*Digits-1:0];
  assign mdig = q_q[4*di_q[IdxW-1:0] +: 4];
  assign qdx = IdxW'(di_q - 1'b1);

  assign req_i.ready = !busy_q && !vld_q;
  assign rsp_o.valid = vld_q;
  assign rsp_o.payload = rsp_q;
  assign usub = (state_q == S_SUB);

  localparam logic [$clog2(AccD+1)-1:0] KEnd = ($clog2(AccD+1))'(AccD);

  always_comb begin
    state_d = state_q; op_d = op_q; acc_d = acc_q; x_d = x_q; t_d = t_q;
    q_d = q_q; cnt_d = cnt_q; di_d = di_q; k_d = k_q; cy_d = cy_q;
    busy_d = busy_q; vld_d = vld_q; rsp_d = rsp_q;
    if (vld_q && rsp_o.ready) vld_d = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid && req_i.ready) begin
          op_d = req_i.payload.opcode;
          k_d = '0; cy_d = 1'b0; cnt_d = '0;
          if (req_i.payload.opcode == OP_RSV || bad_digits(ain) || bad_digits(bin)) begin
            rsp_d = '{result_value: '0, status: ST_INVALID};
            vld_d = 1'b1;
          end else if (req_i.payload.opcode == OP_ADD) begin
            acc_d = (4*AccD)'(ain); x_d = (4*AccD)'(bin);
            busy_d = 1'b1; state_d = S_ADD;
          end else if (req_i.payload.opcode == OP_MUL) begin
            acc_d = '0; x_d = (4*AccD)'(ain); q_d = bin; di_d = '0;
            busy_d = 1'b1; state_d = S_MULN;
          end else if (bin == '0) begin
            rsp_d = '{result_value: '0, status: ST_DIVZERO};
            vld_d = 1'b1;
          end else begin
            acc_d = (4*AccD)'(ain);
            // align divisor to top digit position Digits-1
            x_d = (4*AccD)'(bin) << (4 * (Digits - 1));
            q_d = '0; di_d = (IdxW+1)'(Digits);
            busy_d = 1'b1; state_d = S_SUB; t_d = '0;
          end
        end
      end
      S_ADD: begin
        acc_d[4*kx +: 4] = ur; cy_d = ucy;
        if (k_q == KEnd - 1'b1) begin
          k_d = '0; cy_d = 1'b0;
          if (op_q == OP_ADD) state_d = S_OUT;
          else if (cnt_q == 4'd1) begin
            x_d = x_q << 4; di_d = di_q + 1'b1; state_d = S_MULN;
          end else begin
            cnt_d = cnt_q - 1'b1;
          end
        end else k_d = k_q + 1'b1;
      end
      S_MULN: begin
        if (di_q == (IdxW+1)'(Digits)) state_d = S_OUT;
        else if (mdig == 4'd0) begin
          x_d = x_q << 4; di_d = di_q + 1'b1;
        end else begin
          cnt_d = mdig; k_d = '0; cy_d = 1'b0; state_d = S_ADD;
        end
      end
      S_SUB: begin
        t_d[4*kx +: 4] = ur; cy_d = ucy;
        if (k_q == KEnd - 1'b1) begin
          k_d = '0; cy_d = 1'b0;
          if (!ucy) begin
            acc_d = t_d;
            q_d[4*qdx +: 4] = q_q[4*qdx +: 4] + 4'd1;
          end else state_d = S_DIVN;
        end else k_d = k_q + 1'b1;
      end
      S_DIVN: begin
        di_d = di_q - 1'b1;
        x_d = x_q >> 4;
        if (di_q == (IdxW+1)'(1)) state_d = S_OUT;
        else state_d = S_SUB;
      end
      S_OUT: begin
        if (!vld_q) begin
          busy_d = 1'b0; vld_d = 1'b1; state_d = S_IDLE;
          if (op_q == OP_DIV)
            rsp_d = '{result_value: DataW'(q_q), status: ST_OK};
          else if (op_q == OP_ADD)
            rsp_d = '{result_value: DataW'(acc_q[4*Digits-1:0]),
                      status: (acc_q[4*AccD-1:4*Digits] != '0) ? ST_OVERFLOW : ST_OK};
          else
            rsp_d = '{result_value: DataW'(acc_q[4*Digits-1:0]),
                      status: (acc_q[4*AccD-1:4*Digits] != '0) ? ST_OVERFLOW : ST_OK};
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; busy_q <= 1'b0; vld_q <= 1'b0;
    end else begin
      state_q <= state_d; busy_q <= busy_d; vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; acc_q <= acc_d; x_q <= x_d; t_q <= t_d; q_q <= q_d;
    cnt_q <= cnt_d; di_q <= di_d; k_q <= k_d; cy_q <= cy_d; rsp_q <= rsp_d;
  end

endmodule
